// File: src/density_cell_voxel_fill_macros.svh
// ----------------------------------------------------------------------------
// density_cell_voxel_fill_macros
// Assertion macros shared by the checker of the voxel fill block.
// ----------------------------------------------------------------------------
`ifndef DENSITY_CELL_VOXEL_FILL_MACROS_SVH
`define DENSITY_CELL_VOXEL_FILL_MACROS_SVH

// same-cycle implication
`define DCVF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dcvf check failed");

// next-cycle implication
`define DCVF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dcvf check failed");

// implication after a fixed number of cycles
`define DCVF_ASSERT_DLY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("dcvf check failed");

`endif

// File: src/dcvf_pkg.sv
// ----------------------------------------------------------------------------
// dcvf_pkg
// Types and constants of the density cell voxel fill block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcvf_pkg;

	localparam int DENSITY_BITS = 32;
	localparam int ACC_BITS     = DENSITY_BITS + 4;
	localparam int TILE_BITS    = 8;
	localparam int INDEX_BITS   = 15;
	localparam int ROW_CNT_BITS = 5;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_SEA_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FLUID_TILE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOLID_TILE = 2'd2;

	localparam logic [TILE_BITS-1:0] SEA_LEVEL_RST  = 8'd32;
	localparam logic [TILE_BITS-1:0] FLUID_TILE_RST = 8'd11;
	localparam logic [TILE_BITS-1:0] SOLID_TILE_RST = 8'd87;
	localparam logic [TILE_BITS-1:0] EMPTY_TILE     = 8'd0;

	typedef logic signed [DENSITY_BITS-1:0] dens_t;
	typedef logic signed [ACC_BITS-1:0]     acc_t;

	typedef struct packed {
		logic [1:0] cell_x;
		logic [1:0] cell_z;
		logic [3:0] cell_y;
		dens_t      dens_x0z0_lo;
		dens_t      dens_x0z1_lo;
		dens_t      dens_x1z0_lo;
		dens_t      dens_x1z1_lo;
		dens_t      dens_x0z0_hi;
		dens_t      dens_x0z1_hi;
		dens_t      dens_x1z0_hi;
		dens_t      dens_x1z1_hi;
	} cell_in_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] tile_index;
		logic [TILE_BITS-1:0]  tile_z0;
		logic [TILE_BITS-1:0]  tile_z1;
		logic [TILE_BITS-1:0]  tile_z2;
		logic [TILE_BITS-1:0]  tile_z3;
		logic                  last_of_cell;
	} tile_row_t;

endpackage

// File: src/density_cell_voxel_fill.sv
// ----------------------------------------------------------------------------
// density_cell_voxel_fill
// Trilinear upsampling of a coarse density cell into rows of voxel tiles.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------
//  coarse   | start / busy       | dcvf_pkg::cell_in_t
//  row      | strobe             | dcvf_pkg::tile_row_t
//  cfg      | cfg_we, cfg_index  | cfg_data, 8 bits
//
//  a cell gives 32 row beats, one per cycle, set by the row counter that
//  issues one (layer, x step) row into the pipeline each cycle
//  busy drops on the last row issued, so cells follow with no gap
//  first row beat follows the start beat through the row sequencer, then six register stages
//  reset clears sequencer and valid bits, registers take 32 / 11 / 87
//  the receiver cannot stall; every row beat is taken as it is shown
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module density_cell_voxel_fill (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  dcvf_pkg::cell_in_t                  coarse,
	output logic                                strobe,
	output dcvf_pkg::tile_row_t                 row,
	input  logic                                cfg_we,
	input  logic [dcvf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dcvf_pkg::TILE_BITS-1:0]      cfg_data
);

	typedef struct packed {
		logic [1:0] cx;
		logic [1:0] cz;
		logic [3:0] cy;
		logic [2:0] ys;
		logic [1:0] xs;
		logic       last;
	} meta_t;

	localparam logic [dcvf_pkg::ROW_CNT_BITS-1:0] ROW_LAST = 5'd31;

	logic [dcvf_pkg::TILE_BITS-1:0] sea_level_q, fluid_tile_q, solid_tile_q;

	logic                               act_q;
	logic [dcvf_pkg::ROW_CNT_BITS-1:0]  cnt_q;
	logic                               accept;
	logic                               issue;

	dcvf_pkg::acc_t lo_in [4];
	dcvf_pkg::acc_t hi_in [4];
	dcvf_pkg::acc_t lo_q [4];
	dcvf_pkg::acc_t step_q [4];
	logic [1:0] cx_q, cz_q;
	logic [3:0] cy_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	dcvf_pkg::acc_t v_s1 [4];
	dcvf_pkg::acc_t v0_s2, v1_s2, sx1_s2, sx2_s2;
	dcvf_pkg::acc_t d1_s3, d2_s3;
	dcvf_pkg::acc_t d1_s4, sv_s4;
	logic [3:0] pos_s5;
	logic       below_s5;
	dcvf_pkg::acc_t dv [4];
	dcvf_pkg::tile_row_t row_s6;
	logic [dcvf_pkg::TILE_BITS-1:0] base_tile;
	logic [dcvf_pkg::TILE_BITS-1:0] tiles [4];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sea_level_q  <= dcvf_pkg::SEA_LEVEL_RST;
			fluid_tile_q <= dcvf_pkg::FLUID_TILE_RST;
			solid_tile_q <= dcvf_pkg::SOLID_TILE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dcvf_pkg::REG_SEA_LEVEL:  sea_level_q  <= cfg_data;
				dcvf_pkg::REG_FLUID_TILE: fluid_tile_q <= cfg_data;
				dcvf_pkg::REG_SOLID_TILE: solid_tile_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// row sequencer
	assign busy   = act_q && (cnt_q != ROW_LAST);
	assign accept = start && !busy;
	assign issue  = act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			act_q <= (cnt_q != ROW_LAST);
			cnt_q <= dcvf_pkg::ROW_CNT_BITS'(cnt_q + 5'd1);
		end
	end

	always_comb begin
		lo_in[0] = dcvf_pkg::acc_t'(coarse.dens_x0z0_lo);
		lo_in[1] = dcvf_pkg::acc_t'(coarse.dens_x0z1_lo);
		lo_in[2] = dcvf_pkg::acc_t'(coarse.dens_x1z0_lo);
		lo_in[3] = dcvf_pkg::acc_t'(coarse.dens_x1z1_lo);
		hi_in[0] = dcvf_pkg::acc_t'(coarse.dens_x0z0_hi);
		hi_in[1] = dcvf_pkg::acc_t'(coarse.dens_x0z1_hi);
		hi_in[2] = dcvf_pkg::acc_t'(coarse.dens_x1z0_hi);
		hi_in[3] = dcvf_pkg::acc_t'(coarse.dens_x1z1_hi);
	end

	// cell registers: bottom corners and y steps
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int e = 0; e < 4; e++) begin
				lo_q[e]   <= lo_in[e];
				step_q[e] <= dcvf_pkg::acc_t'(hi_in[e] - lo_in[e]) >>> 3;
			end
			cx_q <= coarse.cell_x;
			cz_q <= coarse.cell_z;
			cy_q <= coarse.cell_y;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// s1: edge values at the layer
	always_ff @(posedge clk) begin
		if (issue) begin
			for (int e = 0; e < 4; e++) begin
				v_s1[e] <= lo_q[e] + dcvf_pkg::acc_t'(step_q[e] * $signed({1'b0, cnt_q[4:2]}));
			end
			meta_s1 <= '{cx: cx_q, cz: cz_q, cy: cy_q, ys: cnt_q[4:2], xs: cnt_q[1:0],
				last: (cnt_q == ROW_LAST)};
		end
	end

	// s2: x steps along the z0 and z1 edges
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			v0_s2   <= v_s1[0];
			v1_s2   <= v_s1[1];
			sx1_s2  <= dcvf_pkg::acc_t'(v_s1[2] - v_s1[0]) >>> 2;
			sx2_s2  <= dcvf_pkg::acc_t'(v_s1[3] - v_s1[1]) >>> 2;
			meta_s2 <= meta_s1;
		end
	end

	// s3: row ends at the x step
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			d1_s3   <= v0_s2 + dcvf_pkg::acc_t'(sx1_s2 * $signed({1'b0, meta_s2.xs}));
			d2_s3   <= v1_s2 + dcvf_pkg::acc_t'(sx2_s2 * $signed({1'b0, meta_s2.xs}));
			meta_s3 <= meta_s2;
		end
	end

	// s4: z step
	always_ff @(posedge clk) begin
		if (vld_s3) begin
			d1_s4   <= d1_s3;
			sv_s4   <= dcvf_pkg::acc_t'(d2_s3 - d1_s3) >>> 2;
			meta_s4 <= meta_s3;
		end
	end

	// s5: voxel densities, sign test and sea level test
	always_comb begin
		for (int z = 0; z < 4; z++) begin
			dv[z] = d1_s4 + dcvf_pkg::acc_t'(sv_s4 * $signed({1'b0, 2'(z)}));
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			for (int z = 0; z < 4; z++) begin
				pos_s5[z] <= !dv[z][dcvf_pkg::ACC_BITS-1] && (dv[z] != '0);
			end
			below_s5 <= {1'b0, meta_s4.cy, meta_s4.ys} < sea_level_q;
			meta_s5  <= meta_s4;
		end
	end

	// s6: tile codes and output row
	assign base_tile = below_s5 ? fluid_tile_q : dcvf_pkg::EMPTY_TILE;

	always_comb begin
		for (int z = 0; z < 4; z++) begin
			tiles[z] = pos_s5[z] ? solid_tile_q : base_tile;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s5) begin
			row_s6.tile_index   <= {meta_s5.cx, meta_s5.xs, meta_s5.cz, 2'b00,
				meta_s5.cy, meta_s5.ys};
			row_s6.tile_z0      <= tiles[0];
			row_s6.tile_z1      <= tiles[1];
			row_s6.tile_z2      <= tiles[2];
			row_s6.tile_z3      <= tiles[3];
			row_s6.last_of_cell <= meta_s5.last;
		end
	end

	assign strobe = vld_s6;
	assign row    = row_s6;

endmodule

// File: src/dcvf_checker.sv
// ----------------------------------------------------------------------------
// dcvf_checker
// Port-level checks of the voxel fill block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "density_cell_voxel_fill_macros.svh"

module dcvf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                strobe,
	input dcvf_pkg::tile_row_t row
);

	// a taken cell holds off the next one
	`DCVF_ASSERT_NXT(a_busy_after_start, start && !busy, busy)

	// first row beat of a cell follows the start beat after the pipeline depth
	`DCVF_ASSERT_DLY(a_first_row_latency, start && !busy, 7, strobe)

	// row beats of one cell come without gaps
	`DCVF_ASSERT_NXT(a_rows_contiguous, strobe && !row.last_of_cell, strobe)

	// last beat is the top layer at the last x step
	`DCVF_ASSERT_IMP(a_last_position, strobe && row.last_of_cell,
		row.tile_index[12:11] == 2'd3 && row.tile_index[2:0] == 3'd7)

endmodule

bind density_cell_voxel_fill dcvf_checker u_dcvf_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voxel fill block. Coarse cells go in through the
// start / busy handshake, from a queue that holds cells and register writes.
// A predictor steps through the trilinear interpolation at full integer width
// and expects 32 tile rows for each cell taken. A monitor checks every row
// beat field by field against those expectations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 6;
	localparam int PHASE_CELLS  = 49;

	localparam logic [dcvf_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	localparam dcvf_pkg::dens_t DENS_MAX = 32'sh7FFF_FFFF;
	localparam dcvf_pkg::dens_t DENS_MIN = 32'sh8000_0000;

	typedef enum logic {OP_CELL, OP_CFG} op_kind_t;

	typedef struct {
		op_kind_t                          kind;
		dcvf_pkg::cell_in_t                payload;
		logic [dcvf_pkg::CFG_IDX_BITS-1:0] idx;
		logic [dcvf_pkg::TILE_BITS-1:0]    data;
		int                                gap;
	} op_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              start     = 1'b0;
	dcvf_pkg::cell_in_t                coarse    = '0;
	logic                              cfg_we    = 1'b0;
	logic [dcvf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [dcvf_pkg::TILE_BITS-1:0]    cfg_data  = '0;
	logic                              busy;
	logic                              strobe;
	dcvf_pkg::tile_row_t               row;

	op_t                 pending_ops[$];
	dcvf_pkg::tile_row_t rows_due[$];

	logic [dcvf_pkg::TILE_BITS-1:0] lvl_sea    = dcvf_pkg::SEA_LEVEL_RST;
	logic [dcvf_pkg::TILE_BITS-1:0] tile_fluid = dcvf_pkg::FLUID_TILE_RST;
	logic [dcvf_pkg::TILE_BITS-1:0] tile_solid = dcvf_pkg::SOLID_TILE_RST;

	int cells_offered = 0;
	int cells_taken   = 0;
	int idle_left     = 0;
	int stall_cycles  = 0;
	int rows_seen     = 0;
	int fault_count   = 0;
	bit gaps_on       = 1'b1;

	density_cell_voxel_fill u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.coarse    (coarse),
		.strobe    (strobe),
		.row       (row),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic flag(string msg);
		if (fault_count < 40)
			$display("mismatch: %s", msg);
		fault_count++;
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want)
			flag($sformatf("row beat %0d %s: got %0h, expected %0h", rows_seen, name, got,
				want));
	endtask

	// walks the cell layer by layer, x step by x step, as the block does
	function automatic void predict_rows(dcvf_pkg::cell_in_t c);
		longint                         corner[4];
		longint                         climb[4];
		longint                         d1, d2, s1, s2, dv, sv;
		logic [6:0]                     height;
		logic [dcvf_pkg::TILE_BITS-1:0] base;
		logic [dcvf_pkg::TILE_BITS-1:0] tz[4];
		dcvf_pkg::tile_row_t            r;
		corner[0] = c.dens_x0z0_lo;
		corner[1] = c.dens_x0z1_lo;
		corner[2] = c.dens_x1z0_lo;
		corner[3] = c.dens_x1z1_lo;
		climb[0]  = (longint'(c.dens_x0z0_hi) - corner[0]) >>> 3;
		climb[1]  = (longint'(c.dens_x0z1_hi) - corner[1]) >>> 3;
		climb[2]  = (longint'(c.dens_x1z0_hi) - corner[2]) >>> 3;
		climb[3]  = (longint'(c.dens_x1z1_hi) - corner[3]) >>> 3;
		for (int ys = 0; ys < 8; ys++) begin
			height = {c.cell_y, 3'(ys)};
			base   = (height < lvl_sea) ? tile_fluid : dcvf_pkg::EMPTY_TILE;
			d1     = corner[0];
			d2     = corner[1];
			s1     = (corner[2] - corner[0]) >>> 2;
			s2     = (corner[3] - corner[1]) >>> 2;
			for (int xs = 0; xs < 4; xs++) begin
				dv = d1;
				sv = (d2 - d1) >>> 2;
				for (int zs = 0; zs < 4; zs++) begin
					tz[zs] = (dv > 0) ? tile_solid : base;
					dv += sv;
				end
				r.tile_index   = {c.cell_x, 2'(xs), c.cell_z, 2'b00, height};
				r.tile_z0      = tz[0];
				r.tile_z1      = tz[1];
				r.tile_z2      = tz[2];
				r.tile_z3      = tz[3];
				r.last_of_cell = (ys == 7 && xs == 3);
				rows_due.push_back(r);
				d1 += s1;
				d2 += s2;
			end
			for (int e = 0; e < 4; e++)
				corner[e] += climb[e];
		end
	endfunction

	// corners in the order x0z0, x0z1, x1z0, x1z1
	function automatic dcvf_pkg::cell_in_t pack_cell(logic [1:0] x, logic [1:0] z,
		logic [3:0] y, logic [127:0] lo, logic [127:0] hi);
		return dcvf_pkg::cell_in_t'({x, z, y, lo, hi});
	endfunction

	function automatic dcvf_pkg::dens_t rand_dens();
		int mode;
		int pick;
		mode = $urandom_range(0, 3);
		pick = $urandom_range(0, 4);
		if (mode == 0)
			return dcvf_pkg::dens_t'($urandom);
		if (mode == 1)
			return dcvf_pkg::dens_t'(int'($urandom_range(0, 4096)) - 2048);
		if (mode == 2)
			return dcvf_pkg::dens_t'(int'($urandom_range(0, 2097152)) - 1048576);
		if (pick == 0)
			return DENS_MAX;
		if (pick == 1)
			return DENS_MIN;
		return dcvf_pkg::dens_t'(pick - 3);
	endfunction

	// mostly terrain-like cells: dense at the bottom, open at the top
	function automatic dcvf_pkg::cell_in_t random_cell();
		logic [127:0] lo;
		logic [127:0] hi;
		bit           terrain;
		terrain = ($urandom_range(0, 2) != 0);
		for (int e = 0; e < 4; e++) begin
			if (terrain) begin
				lo[e*32 +: 32] = int'($urandom_range(0, 524288)) - 65536;
				hi[e*32 +: 32] = 65536 - int'($urandom_range(0, 524288));
			end else begin
				lo[e*32 +: 32] = rand_dens();
				hi[e*32 +: 32] = rand_dens();
			end
		end
		return pack_cell(2'($urandom), 2'($urandom), 4'($urandom), lo, hi);
	endfunction

	task automatic queue_cell(dcvf_pkg::cell_in_t c);
		op_t o;
		o.kind    = OP_CELL;
		o.payload = c;
		o.idx     = '0;
		o.data    = '0;
		o.gap     = (gaps_on && $urandom_range(0, 2) == 0) ? int'($urandom_range(1, 16)) : 0;
		pending_ops.push_back(o);
	endtask

	task automatic queue_cfg(logic [dcvf_pkg::CFG_IDX_BITS-1:0] idx,
		logic [dcvf_pkg::TILE_BITS-1:0] data);
		op_t o;
		o.kind    = OP_CFG;
		o.payload = '0;
		o.idx     = idx;
		o.data    = data;
		o.gap     = 0;
		pending_ops.push_back(o);
	endtask

	always @(negedge clk) begin : drive
		op_t  head;
		logic nxt_start;
		logic nxt_we;
		nxt_start = 1'b0;
		nxt_we    = 1'b0;
		if (arst_n) begin
			if (start && cells_taken != cells_offered) begin
				nxt_start = 1'b1;
			end else if (idle_left > 0) begin
				if (!busy)
					idle_left--;
			end else if (pending_ops.size() > 0) begin
				head = pending_ops[0];
				if (head.kind == OP_CELL) begin
					nxt_start = 1'b1;
					coarse    <= head.payload;
					idle_left = head.gap;
					cells_offered++;
					void'(pending_ops.pop_front());
				end else if (rows_due.size() == 0 && !busy && !strobe) begin
					nxt_we    = 1'b1;
					cfg_index <= head.idx;
					cfg_data  <= head.data;
					void'(pending_ops.pop_front());
				end
			end
		end
		start  <= nxt_start;
		cfg_we <= nxt_we;
	end

	always @(posedge clk) begin : observe
		dcvf_pkg::tile_row_t want;
		if (arst_n) begin
			if (strobe) begin
				if (rows_due.size() == 0) begin
					flag($sformatf("row beat %0d with nothing expected, index %0h", rows_seen,
						row.tile_index));
				end else begin
					want = rows_due.pop_front();
					compare_field("tile_index", row.tile_index, want.tile_index);
					compare_field("tile_z0", row.tile_z0, want.tile_z0);
					compare_field("tile_z1", row.tile_z1, want.tile_z1);
					compare_field("tile_z2", row.tile_z2, want.tile_z2);
					compare_field("tile_z3", row.tile_z3, want.tile_z3);
					compare_field("last_of_cell", row.last_of_cell, want.last_of_cell);
				end
				rows_seen++;
			end
			if (start && !busy) begin
				predict_rows(coarse);
				cells_taken <= cells_taken + 1;
			end
			if (cfg_we) begin
				case (cfg_index)
					dcvf_pkg::REG_SEA_LEVEL:  lvl_sea    = cfg_data;
					dcvf_pkg::REG_FLUID_TILE: tile_fluid = cfg_data;
					dcvf_pkg::REG_SOLID_TILE: tile_solid = cfg_data;
					default: ;
				endcase
			end
			if (strobe || (start && !busy) || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [dcvf_pkg::TILE_BITS-1:0] sea_pick;

		// reset register values
		queue_cell(pack_cell(2'd0, 2'd0, 4'd0, 128'h0, 128'h0));
		queue_cell(pack_cell(2'd3, 2'd3, 4'd15, {4{DENS_MAX}}, {4{DENS_MAX}}));
		queue_cell(pack_cell(2'd3, 2'd3, 4'd3, {4{DENS_MIN}}, {4{DENS_MIN}}));
		queue_cell(pack_cell(2'd1, 2'd2, 4'd4, {4{DENS_MIN}}, {4{DENS_MAX}}));
		queue_cell(pack_cell(2'd2, 2'd1, 4'd3, {4{DENS_MAX}}, {4{DENS_MIN}}));
		queue_cell(pack_cell(2'd0, 2'd3, 4'd7, {DENS_MAX, 32'h0, 32'h0, DENS_MIN},
			{DENS_MIN, 32'h0, 32'h0, DENS_MAX}));
		queue_cell(pack_cell(2'd3, 2'd0, 4'd2, {4{32'h1}}, {4{32'hFFFF_FFFF}}));
		queue_cell(pack_cell(2'd2, 2'd2, 4'd9, {DENS_MAX, DENS_MIN, DENS_MIN, DENS_MAX},
			{DENS_MIN, DENS_MAX, DENS_MAX, DENS_MIN}));

		// sea level zero: nothing turns fluid
		queue_cfg(dcvf_pkg::REG_SEA_LEVEL, 8'd0);
		queue_cfg(dcvf_pkg::REG_FLUID_TILE, 8'd255);
		queue_cfg(dcvf_pkg::REG_SOLID_TILE, 8'd0);
		queue_cell(pack_cell(2'd0, 2'd0, 4'd0, {4{DENS_MIN}}, {4{DENS_MIN}}));
		queue_cell(pack_cell(2'd1, 2'd1, 4'd1, {32'h1, 32'h0, 32'hFFFF_FFFF, 32'h1},
			{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0}));
		queue_cell(pack_cell(2'd3, 2'd3, 4'd15, {4{DENS_MAX}}, {4{DENS_MIN}}));

		// sea level over every height
		queue_cfg(dcvf_pkg::REG_SEA_LEVEL, 8'd128);
		queue_cfg(dcvf_pkg::REG_FLUID_TILE, 8'hAA);
		queue_cfg(dcvf_pkg::REG_SOLID_TILE, 8'h55);
		queue_cell(pack_cell(2'd3, 2'd3, 4'd15, {4{DENS_MIN}}, {4{DENS_MIN}}));
		queue_cell(pack_cell(2'd0, 2'd1, 4'd8, 128'h0, 128'h0));

		queue_cfg(dcvf_pkg::REG_SEA_LEVEL, 8'd127);
		queue_cell(pack_cell(2'd2, 2'd3, 4'd15, {4{DENS_MIN}}, {4{DENS_MIN}}));

		// spare index must leave the registers alone
		queue_cfg(REG_SPARE, 8'hFF);
		queue_cfg(dcvf_pkg::REG_SEA_LEVEL, 8'd255);
		queue_cell(pack_cell(2'd1, 2'd0, 4'd15, {32'h0, 32'h1, 32'hFFFF_FFFF, DENS_MAX},
			{DENS_MIN, 32'h0, 32'h1, 32'hFFFF_FFFF}));

		for (int ph = 0; ph < PHASES; ph++) begin
			gaps_on  = (ph != PHASES - 1);
			sea_pick = 8'($urandom_range(0, 128));
			if ($urandom_range(0, 3) == 0)
				sea_pick = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
			queue_cfg(dcvf_pkg::REG_SEA_LEVEL, sea_pick);
			queue_cfg(dcvf_pkg::REG_FLUID_TILE, 8'($urandom));
			queue_cfg(dcvf_pkg::REG_SOLID_TILE, 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				queue_cfg(REG_SPARE, 8'($urandom));
			repeat (PHASE_CELLS) queue_cell(random_cell());
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(pending_ops.size() == 0 && cells_taken == cells_offered
			&& rows_due.size() == 0) && stall_cycles < STALL_LIMIT)
			@(negedge clk);

		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("density_cell_voxel_fill test failed");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (rows_due.size() != 0)
				flag($sformatf("%0d row beats never arrived", rows_due.size()));
			if (fault_count == 0) begin
				$display("density_cell_voxel_fill test passed");
			end else begin
				$display("density_cell_voxel_fill test failed");
			end
		end
		$finish;
	end

endmodule
